// ===== rtl/core/gdq_pkg.sv =====
// shared constants and types for the grain descriptor queue
package gdq_pkg;
	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam logic [16:0] BUF_SIZE_RST = 17'd4096;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_PEEK = 2'd1,
		CMD_POP  = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2,
		ST_EMPTY   = 2'd3
	} stat_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture command word
		logic div_start; // start quotient
		logic div_step;  // one quotient bit
		logic mul_step;  // register product
		logic calc;      // compute timeout and length
		logic store;     // write slot, bump tail
		logic pop;       // bump head
		logic rd_front;  // read front slot
		logic tick_rd;   // read lifetime at sweep index
		logic tick_wr;   // write back lifetime
		logic sweep_init;
		logic done;      // present result
		logic [1:0] status;
		logic clr_out;
	} gdq_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic zero_speed;
		logic in_range;
		logic sweep_last;
		logic [1:0] cmd;
	} gdq_stat_t;
endpackage

// ===== rtl/core/gdq_ctrl.sv =====
// controller state machine for the grain descriptor queue
module gdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output gdq_pkg::gdq_ctrl_t  ctrl,
	input  gdq_pkg::gdq_stat_t  stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_DIV, S_CHECK, S_MUL, S_CALC, S_STORE,
		S_FRONT, S_TICK_RD, S_TICK_WR, S_DONE
	} state_t;

	state_t state_q;
	logic [5:0] cnt_q;
	logic [1:0] st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			st_q <= gdq_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					st_q <= gdq_pkg::ST_OK;
					case (stat.cmd)
						gdq_pkg::CMD_ADD: begin
							if (stat.full) begin
								st_q <= gdq_pkg::ST_FULL;
								state_q <= S_DONE;
							end else if (stat.zero_speed) begin
								st_q <= gdq_pkg::ST_INVALID;
								state_q <= S_DONE;
							end else begin
								cnt_q <= 6'd0;
								state_q <= S_DIV;
							end
						end
						gdq_pkg::CMD_TICK: begin
							state_q <= stat.empty ? S_DONE : S_TICK_RD;
						end
						default: begin
							if (stat.empty) begin
								st_q <= gdq_pkg::ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								state_q <= S_FRONT;
							end
						end
					endcase
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd35) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!stat.in_range) begin
						st_q <= gdq_pkg::ST_INVALID;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_CALC;
				S_CALC:  state_q <= S_STORE;
				S_STORE: state_q <= S_DONE;
				S_FRONT: state_q <= S_DONE;
				S_TICK_RD: state_q <= S_TICK_WR;
				S_TICK_WR: state_q <= stat.sweep_last ? S_DONE : S_TICK_RD;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctrl = '0;
		ctrl.load = (state_q == S_IDLE) && start;
		ctrl.div_start = (state_q == S_DISPATCH);
		ctrl.sweep_init = (state_q == S_DISPATCH);
		ctrl.div_step = (state_q == S_DIV);
		ctrl.mul_step = (state_q == S_MUL);
		ctrl.calc = (state_q == S_CALC);
		ctrl.store = (state_q == S_STORE);
		ctrl.rd_front = (state_q == S_FRONT);
		ctrl.pop = (state_q == S_FRONT) && (stat.cmd == gdq_pkg::CMD_POP);
		ctrl.tick_rd = (state_q == S_TICK_RD);
		ctrl.tick_wr = (state_q == S_TICK_WR);
		ctrl.done = (state_q == S_DONE);
		ctrl.status = st_q;
		ctrl.clr_out = (state_q == S_DISPATCH);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |=> !busy)
		else $error("done not followed by idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.store |-> $past(ctrl.calc))
		else $error("store without calc");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.tick_wr |-> $past(ctrl.tick_rd))
		else $error("tick write without read");
endmodule

// ===== rtl/core/gdq_dpath.sv =====
// datapath of the grain descriptor queue: slot memory, divider, pointers
module gdq_dpath #(
	parameter int unsigned TABLE_DEPTH = gdq_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gdq_pkg::gdq_ctrl_t ctrl,
	output gdq_pkg::gdq_stat_t stat,
	input  logic [16:0]        buf_size,
	input  logic [1:0]         command,
	input  logic [23:0]        position,
	input  logic [23:0]        duration,
	input  logic [23:0]        delay,
	input  logic [15:0]        speed,
	input  logic [3:0]         envelope,
	input  logic [15:0]        tick_amount,
	output logic               done,
	output logic [1:0]         status,
	output logic [23:0]        out_position,
	output logic [23:0]        out_duration,
	output logic [23:0]        out_delay,
	output logic [15:0]        out_speed,
	output logic [3:0]         out_envelope,
	output logic [31:0]        out_lifetime,
	output logic [16:0]        out_timeout,
	output logic [16:0]        out_grain_length,
	output logic [3:0]         occupancy
);
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned SW = 24 + 24 + 24 + 16 + 4 + 17 + 17;
	localparam logic [IW:0] DEPTH_C = (IW+1)'(TABLE_DEPTH);

	logic [SW-1:0] mem_q [TABLE_DEPTH];
	logic [31:0]   life_q [TABLE_DEPTH];

	logic [IW-1:0] head_q, tail_q, sw_q;
	logic [1:0]  cmd_q;
	logic [23:0] pos_q, dur_q, dly_q;
	logic [15:0] spd_q, amt_q;
	logic [3:0]  env_q;
	logic [35:0] quo_q;   // quotient, also dividend shifter
	logic [15:0] rem_q;
	logic [39:0] prod_q;
	logic [16:0] tmo_q, gl_q;
	logic [31:0] life_rd_q;
	logic [IW-1:0] tail_nx, head_nx, sw_nx;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		logic [IW:0] s;
		s = {1'b0, i} + 1'b1;
		return (s == DEPTH_C) ? '0 : s[IW-1:0];
	endfunction

	assign tail_nx = nxt(tail_q);
	assign head_nx = nxt(head_q);
	assign sw_nx = nxt(sw_q);

	logic [IW:0] cnt_full;
	assign cnt_full = (tail_q >= head_q) ? {1'b0, tail_q} - {1'b0, head_q}
		: {1'b0, tail_q} + DEPTH_C - {1'b0, head_q};

	// restoring divide, one bit a cycle
	logic [16:0] trial;
	assign trial = {rem_q, quo_q[35]} - {1'b0, spd_q};

	logic [35:0] lim;
	logic [36:0] dsum;
	logic [36:0] t1;
	logic [36:0] t2;
	assign lim = {11'd0, buf_size, 8'd0};
	assign dsum = {13'd0, dly_q} + {1'b0, quo_q};
	assign t1 = ({1'b0, lim} >= dsum) ? ({1'b0, lim} - dsum) >> 8 : '0;
	assign t2 = dsum >> 8;

	logic [20:0] glp;
	assign glp = {1'b0, prod_q[39:20]} + 21'd1;

	assign stat.full = (tail_nx == head_q);
	assign stat.empty = (head_q == tail_q);
	assign stat.zero_speed = (spd_q == 16'd0);
	assign stat.in_range = (quo_q >= 36'd512) && (quo_q < lim);
	assign stat.sweep_last = (sw_nx == tail_q);
	assign stat.cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			done <= 1'b0;
		end else begin
			done <= ctrl.done;
			if (ctrl.store) tail_q <= tail_nx;
			if (ctrl.pop) head_q <= head_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			pos_q <= position;
			dur_q <= duration;
			dly_q <= delay;
			spd_q <= speed;
			env_q <= envelope;
			amt_q <= tick_amount;
		end
		if (ctrl.div_start) begin
			quo_q <= {dur_q, 12'd0};
			rem_q <= '0;
		end
		if (ctrl.div_step) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[34:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[35]};
				quo_q <= {quo_q[34:0], 1'b0};
			end
		end
		if (ctrl.mul_step) prod_q <= dur_q * spd_q;
		if (ctrl.calc) begin
			tmo_q <= (t1 < t2) ? t1[16:0] : t2[16:0];
			gl_q <= ({4'd0, glp} > {8'd0, buf_size}) ? buf_size : glp[16:0];
		end
		if (ctrl.store) begin
			mem_q[tail_q] <= {pos_q, dur_q, dly_q, spd_q, env_q, tmo_q, gl_q};
			life_q[tail_q] <= '0;
		end
		if (ctrl.sweep_init) sw_q <= head_q;
		if (ctrl.tick_rd) life_rd_q <= life_q[sw_q];
		if (ctrl.tick_wr) begin
			life_q[sw_q] <= (life_rd_q > ~{16'd0, amt_q}) ? 32'hFFFF_FFFF
				: life_rd_q + {16'd0, amt_q};
			sw_q <= sw_nx;
		end
		if (ctrl.clr_out) begin
			{out_position, out_duration, out_delay, out_speed, out_envelope,
				out_timeout, out_grain_length} <= '0;
			out_lifetime <= '0;
		end
		if (ctrl.rd_front) begin
			{out_position, out_duration, out_delay, out_speed, out_envelope,
				out_timeout, out_grain_length} <= mem_q[head_q];
			out_lifetime <= life_q[head_q];
		end
		if (ctrl.done) begin
			status <= ctrl.status;
			occupancy <= 4'(cnt_full);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.store |-> !stat.full)
		else $error("store into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !stat.empty)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.store |=> tail_q != head_q)
		else $error("queue empty after store");
endmodule

// ===== rtl/core/grain_descriptor_queue_unit.sv =====
// top level of the grain descriptor queue
// Command-style ring queue of grain descriptors, at most TABLE_DEPTH-1 grains.
// A word is taken on start while busy is low; the result word appears on the
// output ports with done high for exactly one cycle, and the receiver cannot
// stall it. Every command gives one result with status and occupancy.
// Add runs a bit-serial quotient of duration*4096 over speed, a range check,
// a product and the timeout/length calculation; peek/pop read the front
// slot; tick reads and writes back each stored grain's lifetime in turn;
// early rejects go straight to the result. One command at a time.
// buffer_size is written on cfg_valid/cfg_ready; ready is high while idle.
// Reset clears head, tail and control and sets buffer_size to 4096; slot
// contents are undefined until written.
module grain_descriptor_queue_unit #(
	parameter int unsigned TABLE_DEPTH = gdq_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [23:0] position,
	input  logic [23:0] duration,
	input  logic [23:0] delay,
	input  logic [15:0] speed,
	input  logic [3:0]  envelope,
	input  logic [15:0] tick_amount,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [23:0] out_position,
	output logic [23:0] out_duration,
	output logic [23:0] out_delay,
	output logic [15:0] out_speed,
	output logic [3:0]  out_envelope,
	output logic [31:0] out_lifetime,
	output logic [16:0] out_timeout,
	output logic [16:0] out_grain_length,
	output logic [3:0]  occupancy
);
	gdq_pkg::gdq_ctrl_t ctrl;
	gdq_pkg::gdq_stat_t stat;
	logic [16:0] buf_size_q;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) buf_size_q <= gdq_pkg::BUF_SIZE_RST;
		else if (cfg_valid && cfg_ready) buf_size_q <= cfg_data;
	end

	gdq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ctrl(ctrl), .stat(stat)
	);

	gdq_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.buf_size(buf_size_q), .command(command), .position(position),
		.duration(duration), .delay(delay), .speed(speed),
		.envelope(envelope), .tick_amount(tick_amount), .done(done),
		.status(status), .out_position(out_position),
		.out_duration(out_duration), .out_delay(out_delay),
		.out_speed(out_speed), .out_envelope(out_envelope),
		.out_lifetime(out_lifetime), .out_timeout(out_timeout),
		.out_grain_length(out_grain_length), .occupancy(occupancy)
	);
endmodule
